### design/palette_nearest_color_search_assert.svh
// Assertion macros for the palette search checker
`ifndef PALETTE_NEAREST_COLOR_SEARCH_ASSERT_SVH
`define PALETTE_NEAREST_COLOR_SEARCH_ASSERT_SVH

// same-cycle implication
`define PNCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PNCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/pncs_pkg.sv
package pncs_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 256;
	localparam int unsigned COLOUR_W = 8;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned DIST_W = 10;

	localparam logic [DIST_W-1:0] DIST_INIT = '1;
	localparam logic [DIST_W-1:0] DIST_MAX = 10'd765;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	// word travelling along the cell chain
	typedef struct packed {
		logic                vld;
		action_t             act;
		logic [INDEX_W-1:0]  idx;
		logic [COLOUR_W-1:0] red;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] blue;
		logic [DIST_W-1:0]   score;
		logic [INDEX_W-1:0]  best;
	} chain_t;

	function automatic logic [COLOUR_W-1:0] abs_diff(input logic [COLOUR_W-1:0] a,
			input logic [COLOUR_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

### design/pncs_if.sv
interface pncs_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] entry_index;
	logic [7:0] red_value;
	logic [7:0] green_value;
	logic [7:0] blue_value;

	modport source (output valid, action, entry_index, red_value, green_value, blue_value,
		input ready);
	modport sink (input valid, action, entry_index, red_value, green_value, blue_value,
		output ready);
endinterface

interface pncs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] nearest_index;
	logic [9:0] nearest_distance;

	modport source (output valid, nearest_index, nearest_distance, input ready);
	modport sink (input valid, nearest_index, nearest_distance, output ready);
endinterface

### design/palette_nearest_color_search.sv
// Channel  Dir  Words                                         Payload
// in_ch    in   palette write or colour query                 action, entry_index, r/g/b
// out_ch   out  one per query, none per write                 nearest_index, nearest_distance
//
// One input word accepted per cycle while in_ch.ready is high; each word walks a chain
// of PALETTE_ENTRIES cells, one cell per palette entry. A query result passes through
// the register of every cell and then the output register before it is offered.
// Reset clears word valid flags only; palette contents are unknown until written.
// A result held with out_ch.ready low freezes the chain and drops in_ch.ready once a
// second query reaches the chain end.
module palette_nearest_color_search
	import pncs_pkg::*;
#(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pncs_in_if.sink     in_ch,
	pncs_out_if.source  out_ch
);

	chain_t             link [PALETTE_ENTRIES+1];
	chain_t             last;
	logic               adv;
	logic               out_free;
	logic               last_query;
	logic               out_vld_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic [DIST_W-1:0]  out_dist_q;

	always_comb begin
		link[0].vld   = in_ch.valid;
		link[0].act   = action_t'(in_ch.action);
		link[0].idx   = in_ch.entry_index;
		link[0].red   = in_ch.red_value;
		link[0].green = in_ch.green_value;
		link[0].blue  = in_ch.blue_value;
		link[0].score = DIST_INIT;
		link[0].best  = '0;
	end

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		pncs_cell #(
			.CELL_INDEX(INDEX_W'(i))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.up     (link[i]),
			.dn     (link[i+1])
		);
	end

	assign last       = link[PALETTE_ENTRIES];
	assign last_query = last.vld && last.act == ACT_QUERY;
	assign out_free   = !out_vld_q || out_ch.ready;
	assign adv        = out_free || !last_query;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= last_query;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && last_query) begin
			out_idx_q  <= last.best;
			out_dist_q <= last.score;
		end
	end

	assign out_ch.valid            = out_vld_q;
	assign out_ch.nearest_index    = out_idx_q;
	assign out_ch.nearest_distance = out_dist_q;

endmodule

### design/pncs_cell.sv
module pncs_cell
	import pncs_pkg::*;
#(
	parameter logic [INDEX_W-1:0] CELL_INDEX = '0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  chain_t up,
	output chain_t dn
);

	logic [COLOUR_W-1:0] entry_red_q;
	logic [COLOUR_W-1:0] entry_green_q;
	logic [COLOUR_W-1:0] entry_blue_q;
	logic                vld_q;
	chain_t              word_q;
	chain_t              word_nxt;
	logic [DIST_W-1:0]   cur_score;
	logic                hit_wr;

	always_comb begin
		cur_score = DIST_W'(abs_diff(entry_red_q, up.red))
			+ DIST_W'(abs_diff(entry_green_q, up.green))
			+ DIST_W'(abs_diff(entry_blue_q, up.blue));
		word_nxt = up;
		if (up.act == ACT_QUERY && cur_score < up.score) begin
			word_nxt.score = cur_score;
			word_nxt.best  = CELL_INDEX;
		end
	end

	assign hit_wr = adv && up.vld && up.act == ACT_WRITE && up.idx == CELL_INDEX;

	always_ff @(posedge clk) begin
		if (hit_wr) begin
			entry_red_q   <= up.red;
			entry_green_q <= up.green;
			entry_blue_q  <= up.blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= up.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= word_nxt;
		end
	end

	always_comb begin
		dn     = word_q;
		dn.vld = vld_q;
	end

endmodule

### design/pncs_checker.sv
`include "palette_nearest_color_search_assert.svh"

module pncs_checker
	import pncs_pkg::*;
#(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] nearest_index,
	input logic [9:0] nearest_distance
);

	localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

	// stalled result holds
	`PNCS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(nearest_index) && $stable(nearest_distance),
		"result changed while stalled")

	// input backpressure only from a blocked result
	`PNCS_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready,
		"input stalled without blocked result")

	`PNCS_ASSERT_NOW(a_dist_range, clk, arst_n, out_valid, nearest_distance <= DIST_MAX,
		"distance out of range")

	`PNCS_ASSERT_NOW(a_index_range, clk, arst_n, out_valid,
		{1'b0, nearest_index} < ENTRY_LIMIT, "index beyond palette")

endmodule

bind palette_nearest_color_search pncs_checker #(
	.PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_pncs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.nearest_index    (out_ch.nearest_index),
	.nearest_distance (out_ch.nearest_distance)
);

### verif/pncs_search_check.sv
`timescale 1ns / 1ps

module pncs_search_check
	import pncs_pkg::*;
#(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pncs_in_if          in_ch,
	pncs_out_if         out_ch,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [DIST_W-1:0]  distance;
	} nearest_t;

	logic [COLOUR_W-1:0] pal_red   [256];
	logic [COLOUR_W-1:0] pal_green [256];
	logic [COLOUR_W-1:0] pal_blue  [256];

	nearest_t nearest_q[$];

	function automatic int unsigned channel_gap(input logic [COLOUR_W-1:0] a,
			input logic [COLOUR_W-1:0] b);
		if (a > b) begin
			return int'(a) - int'(b);
		end
		return int'(b) - int'(a);
	endfunction

	// lowest index wins on a tie: only a strictly smaller sum replaces the best
	function automatic nearest_t search_palette(input logic [COLOUR_W-1:0] r,
			input logic [COLOUR_W-1:0] g, input logic [COLOUR_W-1:0] b);
		nearest_t    best;
		int unsigned sum;
		best.index    = '0;
		best.distance = DIST_INIT;
		for (int unsigned i = 0; i < PALETTE_ENTRIES; i++) begin
			sum = channel_gap(pal_red[i], r) + channel_gap(pal_green[i], g)
				+ channel_gap(pal_blue[i], b);
			if (sum < best.distance) begin
				best.distance = sum[DIST_W-1:0];
				best.index    = i[INDEX_W-1:0];
			end
		end
		return best;
	endfunction

	always @(posedge clk) begin
		nearest_t got;
		nearest_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.index    = out_ch.nearest_index;
				got.distance = out_ch.nearest_distance;
				if (nearest_q.size() == 0) begin
					$error("unexpected result word: nearest_index %0d, nearest_distance %0d",
						got.index, got.distance);
					mismatches++;
				end else begin
					want = nearest_q.pop_front();
					if (got.index !== want.index) begin
						$error("nearest_index: expected %0d, actual %0d",
							want.index, got.index);
						mismatches++;
					end
					if (got.distance !== want.distance) begin
						$error("nearest_distance: expected %0d, actual %0d",
							want.distance, got.distance);
						mismatches++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (action_t'(in_ch.action) == ACT_QUERY) begin
					nearest_q.push_back(search_palette(in_ch.red_value, in_ch.green_value,
						in_ch.blue_value));
				end else if (in_ch.entry_index < PALETTE_ENTRIES) begin
					pal_red[in_ch.entry_index]   = in_ch.red_value;
					pal_green[in_ch.entry_index] = in_ch.green_value;
					pal_blue[in_ch.entry_index]  = in_ch.blue_value;
				end
			end
			outstanding = nearest_q.size();
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import pncs_pkg::*;

	localparam int unsigned PAL_N        = PALETTE_ENTRIES_DEF;
	localparam int unsigned RANDOM_WORDS = 1674;
	localparam int unsigned CYCLE_LIMIT  = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned fail_cnt;
	int unsigned pending_cnt;
	int unsigned burst_left = 0;
	int unsigned cycle_cnt = 0;
	logic [7:0]  last_r = '0;
	logic [7:0]  last_g = '0;
	logic [7:0]  last_b = '0;

	pncs_in_if  in_ch ();
	pncs_out_if out_ch ();

	palette_nearest_color_search #(.PALETTE_ENTRIES(PAL_N)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	pncs_search_check #(.PALETTE_ENTRIES(PAL_N)) u_nearest_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (fail_cnt),
		.outstanding (pending_cnt)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// sender offers words in bursts; valid stays high across a burst
	task automatic send_word(input action_t act, input logic [7:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_ch.valid       <= 1'b1;
		in_ch.action      <= act;
		in_ch.entry_index <= idx;
		in_ch.red_value   <= r;
		in_ch.green_value <= g;
		in_ch.blue_value  <= b;
		if (act == ACT_WRITE) begin
			last_r = r;
			last_g = g;
			last_b = b;
		end
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// biased towards extremes and a coarse grid so that ties turn up
	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(0, 3) * 85);
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned sel;
		in_ch.valid       = 1'b0;
		in_ch.action      = ACT_WRITE;
		in_ch.entry_index = '0;
		in_ch.red_value   = '0;
		in_ch.green_value = '0;
		in_ch.blue_value  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every entry written before the first query
		for (int unsigned i = 0; i < PAL_N; i++) begin
			send_word(ACT_WRITE, 8'(i), 8'd0, 8'd0, 8'd0);
		end

		send_word(ACT_QUERY, 8'd7,   8'd255, 8'd255, 8'd255);
		send_word(ACT_QUERY, 8'd0,   8'd0,   8'd0,   8'd0);
		send_word(ACT_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
		send_word(ACT_QUERY, 8'd255, 8'd255, 8'd255, 8'd255);
		send_word(ACT_QUERY, 8'd3,   8'd128, 8'd128, 8'd128);
		send_word(ACT_WRITE, 8'd128, 8'd200, 8'd100, 8'd50);
		send_word(ACT_WRITE, 8'd129, 8'd200, 8'd100, 8'd50);
		send_word(ACT_QUERY, 8'd129, 8'd200, 8'd100, 8'd50);
		send_word(ACT_QUERY, 8'd64,  8'd201, 8'd99,  8'd52);
		send_word(ACT_WRITE, 8'd0,   8'd255, 8'd0,   8'd255);
		send_word(ACT_WRITE, 8'd1,   8'd0,   8'd255, 8'd0);
		send_word(ACT_QUERY, 8'd1,   8'd255, 8'd0,   8'd255);
		send_word(ACT_QUERY, 8'd0,   8'd0,   8'd255, 8'd0);
		send_word(ACT_WRITE, 8'd170, 8'd170, 8'd170, 8'd170);
		send_word(ACT_QUERY, 8'd255, 8'd170, 8'd170, 8'd171);
		send_word(ACT_WRITE, 8'd2,   8'd255, 8'd255, 8'd255);
		send_word(ACT_QUERY, 8'd85,  8'd255, 8'd255, 8'd254);
		send_word(ACT_WRITE, 8'd255, 8'd0,   8'd0,   8'd0);
		send_word(ACT_QUERY, 8'd170, 8'd127, 8'd127, 8'd127);
		send_word(ACT_QUERY, 8'd129, 8'd0,   8'd0,   8'd1);

		for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
			sel = $urandom_range(0, 99);
			if (n < PAL_N) begin
				send_word(ACT_WRITE, 8'(n), pick_level(), pick_level(), pick_level());
			end else if (sel < 40) begin
				send_word(ACT_WRITE, 8'($urandom), pick_level(), pick_level(), pick_level());
			end else if (sel < 55) begin
				send_word(ACT_QUERY, 8'($urandom), last_r, last_g, last_b);
			end else begin
				send_word(ACT_QUERY, 8'($urandom), pick_level(), pick_level(), pick_level());
			end
		end
		in_ch.valid <= 1'b0;

		wait (pending_cnt == 0);
		repeat (PAL_N + 40) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// receiver stalls on its own pattern, with two long hold-offs to fill the chain
	initial begin
		int unsigned rx_cycle;
		int unsigned mode;
		int unsigned hold_left;
		out_ch.ready = 1'b0;
		rx_cycle     = 0;
		mode         = 0;
		hold_left    = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle == 1500 || rx_cycle == 3500) begin
				hold_left = 800;
			end
			if (rx_cycle % 150 == 0) begin
				mode = $urandom_range(0, 3);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= ($urandom_range(0, 9) < 7);
					2: out_ch.ready <= ($urandom_range(0, 9) < 2);
					default: out_ch.ready <= (rx_cycle % 5 != 0);
				endcase
			end
		end
	end

endmodule
